FILE: hw/rtl/gwa_pkg.sv
// shared types, constants and helper functions of the gravity well block
package gwa_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned LOG_STEPS     = 16;
  localparam int unsigned EXP_STEPS     = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WELL_X    = 3'd0,
    REG_WELL_Y    = 3'd1,
    REG_STRENGTH  = 3'd2,
    REG_FALLOFF   = 3'd3,
    REG_TIME_STEP = 3'd4
  } reg_idx_e;

  localparam logic [15:0] FALLOFF_RST = 16'h2000;   // 2.0 in Q4.12
  localparam logic [16:0] FALLOFF_ONE = 17'd4096;   // 1.0 in Q4.12
  // 32.0 in Q.16, turns log2 of dist^2 (raw) into log2 of dist^2 in real units
  localparam logic signed [23:0] LOG_BIAS = 24'sd2097152;
  localparam logic signed [46:0] EXP_BIAS = 47'sd35184372088832;  // 2^45
  localparam logic signed [17:0] GI_BIAS  = 18'sd65536;
  localparam logic signed [19:0] SHIFT_BIAS = 20'sd63;

  // configuration seen by the back end
  typedef struct packed {
    logic [31:0] strength;
    logic [15:0] falloff;
    logic [23:0] time_step;
  } cfg_t;

  // classified body word passed from front to back
  typedef struct packed {
    logic        zero;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] abs_x;
    logic [31:0] abs_y;
  } item_t;

  // 2^(2^-(k+1)) in 1.31
  function automatic logic [31:0] exp2_frac(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'd3037000500;
      4'd1:    r = 32'd2553802833;
      4'd2:    r = 32'd2341847524;
      4'd3:    r = 32'd2242560891;
      4'd4:    r = 32'd2194507417;
      4'd5:    r = 32'd2170880222;
      4'd6:    r = 32'd2159144272;
      4'd7:    r = 32'd2153306067;
      4'd8:    r = 32'd2150392887;
      4'd9:    r = 32'd2148937775;
      4'd10:   r = 32'd2148210589;
      4'd11:   r = 32'd2147847086;
      4'd12:   r = 32'd2147665360;
      4'd13:   r = 32'd2147574501;
      4'd14:   r = 32'd2147529074;
      default: r = 32'd2147506361;
    endcase
    return r;
  endfunction

  // index of the top set bit, zero for a zero word
  function automatic logic [6:0] msb_index(input logic [64:0] v);
    logic [6:0] idx;
    idx = '0;
    for (int i = 0; i < 65; i++) begin
      if (v[i]) idx = 7'(i);
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/gravity_well_acceleration.sv
// top level of the gravity well acceleration block
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  body in   | in        | s_axis_tvalid / s_axis_tready | tdata: body_x, body_y
//  delta out | out       | m_axis_tvalid / m_axis_tready | tdata: delta_vx, delta_vy; tuser: applied
//  config    | in        | cfg_valid_i / cfg_ready_o     | cfg_addr_i, cfg_data_i
//
// one body word per cycle is accepted while the queue has room; the result word passes
// through 4 setup stages, 16 log squaring stages, 2 exponent stages, 16 exp2 product
// stages, 3 scaling stages and the output register, a chain set by the dependent 32x32
// products. a four-word queue sits between front and back; a stall on the output
// freezes the back pipeline and the queue absorbs incoming words.
// reset is asynchronous and clears valid state and the configuration registers to their defaults.
module gravity_well_acceleration #(
  parameter int unsigned POS_WIDTH = gwa_pkg::POS_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // body_x, body_y
  input  logic [((2*POS_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // delta_vx, delta_vy
  output logic [63:0]                         m_axis_tdata,
  // applied
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gwa_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [gwa_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import gwa_pkg::*;

  item_t       fr_item, q_item;
  cfg_t        cfg;
  logic        q_valid, q_pop;
  logic [31:0] dvx, dvy;
  logic        applied;

  gwa_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .body_x_i    (s_axis_tdata[POS_WIDTH-1:0]),
    .body_y_i    (s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .item_o      (fr_item),
    .cfg_o       (cfg)
  );

  gwa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  gwa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (q_valid),
    .in_item_i   (q_item),
    .in_pop_o    (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .delta_vx_o  (dvx),
    .delta_vy_o  (dvy),
    .applied_o   (applied)
  );

  assign m_axis_tdata = {dvy, dvx};
  assign m_axis_tuser = applied;

endmodule

FILE: hw/rtl/gwa_front.sv
// front end: configuration registers and body offset classification
module gwa_front #(
  parameter int unsigned POS_WIDTH = gwa_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gwa_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [gwa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [POS_WIDTH-1:0]            body_x_i,
  input  logic [POS_WIDTH-1:0]            body_y_i,
  output gwa_pkg::item_t                  item_o,
  output gwa_pkg::cfg_t                   cfg_o
);
  import gwa_pkg::*;

  localparam int unsigned PW = (POS_WIDTH > 32) ? 32 : POS_WIDTH;

  logic [31:0] well_x_q, well_y_q, strength_q;
  logic [15:0] falloff_q;
  logic [23:0] time_step_q;

  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      well_x_q    <= '0;
      well_y_q    <= '0;
      strength_q  <= '0;
      falloff_q   <= FALLOFF_RST;
      time_step_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_WELL_X:    well_x_q    <= cfg_data_i;
        REG_WELL_Y:    well_y_q    <= cfg_data_i;
        REG_STRENGTH:  strength_q  <= cfg_data_i;
        REG_FALLOFF:   falloff_q   <= cfg_data_i[15:0];
        REG_TIME_STEP: time_step_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{strength: strength_q, falloff: falloff_q, time_step: time_step_q};

  // sign extended positions and offsets
  logic signed [32:0] wx, wy, bx, by, dx, dy;
  assign wx = $signed({{(33-PW){well_x_q[PW-1]}}, well_x_q[PW-1:0]});
  assign wy = $signed({{(33-PW){well_y_q[PW-1]}}, well_y_q[PW-1:0]});
  assign bx = $signed({{(33-PW){body_x_i[PW-1]}}, body_x_i[PW-1:0]});
  assign by = $signed({{(33-PW){body_y_i[PW-1]}}, body_y_i[PW-1:0]});
  assign dx = wx - bx;
  assign dy = wy - by;

  // magnitude, sign and zero vector flag
  logic [32:0] nx, ny;
  assign nx = 33'(-dx);
  assign ny = 33'(-dy);
  always_comb begin
    item_o.zero  = (dx == '0) && (dy == '0);
    item_o.neg_x = dx[32];
    item_o.neg_y = dy[32];
    item_o.abs_x = dx[32] ? nx[31:0] : dx[31:0];
    item_o.abs_y = dy[32] ? ny[31:0] : dy[31:0];
  end

endmodule

FILE: hw/rtl/gwa_queue.sv
// short queue of classified body words between front and back
module gwa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  gwa_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output gwa_pkg::item_t pop_item_o
);
  import gwa_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  item_t         mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != AW'(0) + (AW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
      if (push && !pop)      count_q <= count_q + (AW+1)'(1);
      else if (pop && !push) count_q <= count_q - (AW+1)'(1);
    end
  end

endmodule

FILE: hw/rtl/gwa_back.sv
// back end: pipelined log / scale / exp datapath with output register
module gwa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gwa_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  gwa_pkg::item_t in_item_i,
  output logic           in_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    delta_vx_o,
  output logic [31:0]    delta_vy_o,
  output logic           applied_o
);
  import gwa_pkg::*;

  logic en;
  logic out_valid_q;
  assign en       = !out_valid_q || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  // strength * time_step, normalized to 32 bits (follows the registers)
  logic [55:0] pt_q;
  logic [31:0] pm_q;
  logic [4:0]  pe_q;
  logic [6:0]  pt_msb;
  logic [4:0]  pe_d;
  assign pt_msb = msb_index(65'(pt_q));
  assign pe_d   = (pt_msb >= 7'd32) ? 5'(pt_msb - 7'd31) : 5'd0;
  always_ff @(posedge clk_i) begin
    pt_q <= 56'(cfg_i.strength) * 56'(cfg_i.time_step);
    pm_q <= 32'(pt_q >> pe_d);
    pe_q <= pe_d;
  end

  // stage 1: squares
  logic        s1_v_q;
  item_t       s1_it_q;
  logic [63:0] s1_sx_q, s1_sy_q;
  // stage 2: sum of squares
  logic        s2_v_q;
  item_t       s2_it_q;
  logic [64:0] s2_q_q;
  // stage 3: top bit search
  logic        s3_v_q;
  item_t       s3_it_q;
  logic [64:0] s3_q_q;
  logic [6:0]  s3_p_q;
  // stage 4: mantissa
  logic        s4_v_q;
  item_t       s4_it_q;
  logic [31:0] s4_x_q;
  logic [6:0]  s4_p_q;
  logic [64:0] s4_sh;
  assign s4_sh = s3_q_q << (7'd64 - s3_p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_it_q <= in_item_i;
      s1_sx_q <= 64'(in_item_i.abs_x) * 64'(in_item_i.abs_x);
      s1_sy_q <= 64'(in_item_i.abs_y) * 64'(in_item_i.abs_y);
      s2_it_q <= s1_it_q;
      s2_q_q  <= 65'(s1_sx_q) + 65'(s1_sy_q);
      s3_it_q <= s2_it_q;
      s3_q_q  <= s2_q_q;
      s3_p_q  <= msb_index(s2_q_q);
      s4_it_q <= s3_it_q;
      s4_x_q  <= s4_sh[64:33];
      s4_p_q  <= s3_p_q;
    end
  end

  // log fraction: one squaring per stage
  logic        lg_v_q  [LOG_STEPS];
  item_t       lg_it_q [LOG_STEPS];
  logic [31:0] lg_x_q  [LOG_STEPS];
  logic [15:0] lg_f_q  [LOG_STEPS];
  logic [6:0]  lg_p_q  [LOG_STEPS];

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    logic [31:0] x_in;
    logic [15:0] f_in;
    logic [6:0]  p_in;
    item_t       it_in;
    logic        v_in;
    logic [63:0] sq;
    if (k == 0) begin : g_first
      assign x_in  = s4_x_q;
      assign f_in  = '0;
      assign p_in  = s4_p_q;
      assign it_in = s4_it_q;
      assign v_in  = s4_v_q;
    end else begin : g_next
      assign x_in  = lg_x_q[k-1];
      assign f_in  = lg_f_q[k-1];
      assign p_in  = lg_p_q[k-1];
      assign it_in = lg_it_q[k-1];
      assign v_in  = lg_v_q[k-1];
    end
    assign sq = 64'(x_in) * 64'(x_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) lg_v_q[k] <= 1'b0;
      else if (en) lg_v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        lg_it_q[k] <= it_in;
        lg_p_q[k]  <= p_in;
        if (sq[63]) begin
          lg_x_q[k] <= sq[63:32];
          lg_f_q[k] <= f_in | (16'd1 << (LOG_STEPS - 1 - k));
        end else begin
          lg_x_q[k] <= sq[62:31];
          lg_f_q[k] <= f_in;
        end
      end
    end
  end

  // stage 5: scale by the exponent, stage 6: split into integer and fraction
  logic                s5_v_q, s6_v_q;
  item_t               s5_it_q, s6_it_q;
  logic signed [41:0]  s5_e_q;
  logic signed [17:0]  s6_gi_q;
  logic [15:0]         s6_gf_q;
  logic signed [23:0]  l17;
  logic [16:0]         fo;
  logic signed [46:0]  gt;
  logic [32:0]         g16b;
  assign l17  = $signed({1'b0, lg_p_q[LOG_STEPS-1], lg_f_q[LOG_STEPS-1]}) - LOG_BIAS;
  assign fo   = {1'b0, cfg_i.falloff} + FALLOFF_ONE;
  assign gt   = EXP_BIAS - 47'(s5_e_q);
  assign g16b = gt[45:13];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= lg_v_q[LOG_STEPS-1];
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_it_q <= lg_it_q[LOG_STEPS-1];
      s5_e_q  <= 42'(l17) * 42'($signed({1'b0, fo}));
      s6_it_q <= s5_it_q;
      s6_gi_q <= $signed({1'b0, g16b[32:16]}) - GI_BIAS;
      s6_gf_q <= g16b[15:0];
    end
  end

  // exp2 of the fraction: one table product per stage
  logic               ex_v_q  [EXP_STEPS];
  item_t              ex_it_q [EXP_STEPS];
  logic [31:0]        ex_m_q  [EXP_STEPS];
  logic [15:0]        ex_gf_q [EXP_STEPS];
  logic signed [17:0] ex_gi_q [EXP_STEPS];

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
    logic [31:0]        m_in;
    logic [15:0]        gf_in;
    logic signed [17:0] gi_in;
    item_t              it_in;
    logic               v_in;
    logic [63:0]        pr;
    if (k == 0) begin : g_first
      assign m_in  = 32'h8000_0000;
      assign gf_in = s6_gf_q;
      assign gi_in = s6_gi_q;
      assign it_in = s6_it_q;
      assign v_in  = s6_v_q;
    end else begin : g_next
      assign m_in  = ex_m_q[k-1];
      assign gf_in = ex_gf_q[k-1];
      assign gi_in = ex_gi_q[k-1];
      assign it_in = ex_it_q[k-1];
      assign v_in  = ex_v_q[k-1];
    end
    assign pr = 64'(m_in) * 64'(exp2_frac(4'(k)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ex_v_q[k] <= 1'b0;
      else if (en) ex_v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_it_q[k] <= it_in;
        ex_gf_q[k] <= gf_in;
        ex_gi_q[k] <= gi_in;
        ex_m_q[k]  <= gf_in[EXP_STEPS-1-k] ? pr[62:31] : m_in;
      end
    end
  end

  // stage 7: product with strength * time_step, stage 8: normalize and total shift, stage 9: offset products
  logic               s7_v_q, s8_v_q, s9_v_q;
  item_t              s7_it_q, s8_it_q, s9_it_q;
  logic [63:0]        s7_pr_q;
  logic signed [17:0] s7_gi_q;
  logic [31:0]        s8_tm_q;
  logic signed [19:0] s8_sh_q, s9_sh_q;
  logic [63:0]        s9_ux_q, s9_uy_q;
  logic [6:0]         pr_msb;
  logic [5:0]         te;
  assign pr_msb = msb_index(65'(s7_pr_q));
  assign te     = (pr_msb >= 7'd32) ? 6'(pr_msb - 7'd31) : 6'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
      s9_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= ex_v_q[EXP_STEPS-1];
      s8_v_q <= s7_v_q;
      s9_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_it_q <= ex_it_q[EXP_STEPS-1];
      s7_pr_q <= 64'(pm_q) * 64'(ex_m_q[EXP_STEPS-1]);
      s7_gi_q <= ex_gi_q[EXP_STEPS-1];
      s8_it_q <= s7_it_q;
      s8_tm_q <= 32'(s7_pr_q >> te);
      s8_sh_q <= $signed({15'd0, pe_q}) + $signed({14'd0, te}) + 20'(s7_gi_q)
                 - SHIFT_BIAS;
      s9_it_q <= s8_it_q;
      s9_ux_q <= 64'(s8_it_q.abs_x) * 64'(s8_tm_q);
      s9_uy_q <= 64'(s8_it_q.abs_y) * 64'(s8_tm_q);
      s9_sh_q <= s8_sh_q;
    end
  end

  // shift with saturation and sign
  function automatic logic [31:0] scale(input logic neg, input logic [63:0] u,
                                        input logic signed [19:0] sh);
    logic [63:0] lim, mag;
    logic [19:0] nsh;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    nsh = 20'(-sh);
    mag = '0;
    if (u == '0) begin
      mag = '0;
    end else if (!sh[19]) begin
      if (sh >= 20'sd32) mag = lim;
      else if (u > (lim >> sh[4:0])) mag = lim;
      else mag = u << sh[4:0];
    end else begin
      if (nsh >= 20'd64) mag = '0;
      else mag = u >> nsh[5:0];
      if (mag > lim) mag = lim;
    end
    return neg ? 32'(64'd0 - mag) : mag[31:0];
  endfunction

  // output register
  logic [31:0] dvx_q, dvy_q;
  logic        app_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= s9_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s9_it_q.zero) begin
        dvx_q <= '0;
        dvy_q <= '0;
        app_q <= 1'b0;
      end else begin
        dvx_q <= scale(s9_it_q.neg_x, s9_ux_q, s9_sh_q);
        dvy_q <= scale(s9_it_q.neg_y, s9_uy_q, s9_sh_q);
        app_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign delta_vx_o  = dvx_q;
  assign delta_vy_o  = dvy_q;
  assign applied_o   = app_q;

endmodule

FILE: hw/rtl/gwa_checker.sv
// port level checks of the gravity well block and their binding
module gwa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [63:0]                    m_axis_tdata,
  input logic [0:0]                     m_axis_tuser,
  input logic                           cfg_ready_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a body at the well gets a zero increment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
    else $error("nonzero increment with applied clear");

  // no result right out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // register writes are never refused
  assert property (@(posedge clk_i) rst_ni |-> cfg_ready_o)
    else $error("config port not ready");

endmodule

bind gravity_well_acceleration gwa_checker u_gwa_checker (.*);
